// ----- rtl/fixed_block_pool_allocator_unit_macros.svh -----
// Assertion helpers shared by the allocator modules.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FBPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa: implication check failed");

// Next-cycle implication, checked outside reset.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa: next-cycle check failed");

`endif

// ----- rtl/fbpa_pkg.sv -----
package fbpa_pkg;

    localparam int ADDR_W    = 32;
    localparam int STRIDE_W  = 17;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 3;
    localparam int INUSE_W   = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_OWNED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_POOL_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_STRIDE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd2;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 17'd8;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] free_address;
    } fbpa_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   block_address;
        logic [STATUS_W-1:0] status;
        logic [INUSE_W-1:0]  in_use;
    } fbpa_out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic commit;
        logic clr_init;
        logic clr_step;
    } fbpa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic op_free;
        logic addr_null;
        logic div_done;
        logic out_free;
        logic clr_last;
    } fbpa_status_t;

endpackage

// ----- rtl/fbpa_div.sv -----
module fbpa_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [fbpa_pkg::ADDR_W-1:0]   dividend,
    input  logic [fbpa_pkg::STRIDE_W-1:0] divisor,
    output logic [fbpa_pkg::ADDR_W-1:0]   quot,
    output logic [fbpa_pkg::STRIDE_W-1:0] rem,
    output logic                          done
);

    localparam int AW        = fbpa_pkg::ADDR_W;
    localparam int SW        = fbpa_pkg::STRIDE_W;
    localparam int DIV_CNT_W = $clog2(AW);

    logic [AW-1:0]        quot_reg;
    logic [SW-1:0]        rem_reg;
    logic [SW-1:0]        divisor_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [SW:0]   shifted;
    logic [SW:0]   diff;
    logic          take;
    logic [SW-1:0] rem_next;

    // one restoring step per cycle, quotient bits shift in as dividend bits shift out
    always_comb
    begin
        shifted  = {rem_reg, quot_reg[AW-1]};
        diff     = shifted - {1'b0, divisor_reg};
        take     = (shifted >= {1'b0, divisor_reg});
        rem_next = take ? diff[SW-1:0] : shifted[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(AW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= {quot_reg[AW-2:0], take};
            rem_reg  <= rem_next;
        end
    end

    assign quot = quot_reg;
    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

// ----- rtl/fbpa_ctrl.sv -----
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   cfg_fire,
    input  fbpa_pkg::fbpa_status_t status,
    output fbpa_pkg::fbpa_cmd_t    cmd
);

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_IDLE   = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_COMMIT = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // a rebuilding config write in the same cycle wins over a new request
    assign in_ready = (state_reg == S_IDLE) && !cfg_fire;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.clr_init = 1'b1;
                state_next   = S_CLEAR;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc = 1'b1;
                if (status.op_free && !status.addr_null)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (status.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        // every register write rebuilds the pool
        if (cfg_fire)
        begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `FBPA_ASSERT_IMPLY(a_commit_has_slot, clk, rst_n, cmd.commit, status.out_free)
    `FBPA_ASSERT_NEXT(a_load_then_calc, clk, rst_n, cmd.load, cmd.calc)
    `FBPA_ASSERT_IMPLY(a_no_load_while_clearing, clk, rst_n, cmd.clr_step, !in_ready)

endmodule

// ----- rtl/fbpa_datapath.sv -----
`include "fixed_block_pool_allocator_unit_macros.svh"

module fbpa_datapath #(
    parameter int MAX_BLOCKS = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_fire,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]     cfg_data,
    input  fbpa_pkg::fbpa_in_t              in_data,
    input  logic                            out_ready,
    output logic                            out_valid,
    output fbpa_pkg::fbpa_out_t             out_data,
    input  fbpa_pkg::fbpa_cmd_t             cmd,
    output fbpa_pkg::fbpa_status_t          status
);

    localparam int AW     = fbpa_pkg::ADDR_W;
    localparam int SW     = fbpa_pkg::STRIDE_W;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int MEM_W  = CNT_W + 1;
    localparam int PROD_W = CNT_W + SW;
    localparam int SUM_W  = ((PROD_W > AW) ? PROD_W : AW) + 1;
    localparam logic [CNT_W-1:0] EMPTY = CNT_W'(MAX_BLOCKS);
    localparam logic [AW-1:0] ADDR_MASK =
        (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);

    // configuration
    logic [AW-1:0]                  start_reg;
    logic [SW-1:0]                  stride_reg;
    logic [fbpa_pkg::COUNT_W-1:0]   count_reg;

    // request in flight
    logic                           op_reg;
    logic [AW-1:0]                  addr_reg;
    logic [PROD_W-1:0]              prod_reg;
    logic [MEM_W-1:0]               rd_reg;

    // allocator state
    logic [CNT_W-1:0]               top_reg;
    logic [CNT_W-1:0]               top_next;
    logic [CNT_W-1:0]               used_reg;
    logic [CNT_W-1:0]               used_next;
    logic [IDX_W-1:0]               clr_ctr_reg;

    // each word: written flag, then link
    logic [MEM_W-1:0]               link_mem [MAX_BLOCKS];

    logic                           out_valid_reg;
    fbpa_pkg::fbpa_out_t            out_data_reg;
    fbpa_pkg::fbpa_out_t            res;

    logic [CNT_W-1:0]               live;
    logic [CNT_W-1:0]               mul_a;
    logic                           div_start;
    logic [AW-1:0]                  div_quot;
    logic [SW-1:0]                  div_rem;
    logic                           div_done;
    logic [SUM_W-1:0]               end_sum;
    logic [CNT_W:0]                 top_inc;
    logic [CNT_W-1:0]               next_top;
    logic                           alloc_ok;
    logic                           owned;
    logic                           push;

    always_comb
    begin
        if (stride_reg == '0)
        begin
            live = '0;
        end
        else if (32'(count_reg) > 32'(MAX_BLOCKS))
        begin
            live = EMPTY;
        end
        else
        begin
            live = CNT_W'(count_reg);
        end
    end

    assign mul_a     = (op_reg == fbpa_pkg::OP_FREE) ? live : top_reg;
    assign div_start = cmd.calc && (op_reg == fbpa_pkg::OP_FREE);

    fbpa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (addr_reg - start_reg),
        .divisor  (stride_reg),
        .quot     (div_quot),
        .rem      (div_rem),
        .done     (div_done)
    );

    // prod_reg is top*stride for an allocate and live*stride for a free
    assign end_sum  = SUM_W'(start_reg) + SUM_W'(prod_reg);
    assign alloc_ok = (top_reg < live);
    assign top_inc  = {1'b0, top_reg} + (CNT_W + 1)'(1);
    assign owned    = (live != '0) && (addr_reg >= start_reg) &&
                      (SUM_W'(addr_reg) < end_sum) && (div_rem == '0);

    always_comb
    begin
        if (rd_reg[CNT_W])
        begin
            next_top = rd_reg[CNT_W-1:0];
        end
        else if (top_inc < {1'b0, live})
        begin
            next_top = top_inc[CNT_W-1:0];
        end
        else
        begin
            next_top = EMPTY;
        end
    end

    always_comb
    begin
        top_next          = top_reg;
        used_next         = used_reg;
        push              = 1'b0;
        res.block_address = '0;
        res.status        = fbpa_pkg::ST_OK;
        if (op_reg == fbpa_pkg::OP_ALLOC)
        begin
            if (!alloc_ok)
            begin
                res.status = fbpa_pkg::ST_EMPTY;
            end
            else
            begin
                top_next          = next_top;
                res.block_address = end_sum[AW-1:0] & ADDR_MASK;
                if (used_reg < live)
                begin
                    used_next = used_reg + CNT_W'(1);
                end
            end
        end
        else if (addr_reg == '0)
        begin
            res.status = fbpa_pkg::ST_NULL;
        end
        else if (!owned)
        begin
            res.status = fbpa_pkg::ST_NOT_OWNED;
        end
        else if (used_reg == '0)
        begin
            res.status = fbpa_pkg::ST_UNDERFLOW;
        end
        else if (div_quot < AW'(MAX_BLOCKS))
        begin
            push      = 1'b1;
            top_next  = CNT_W'(div_quot);
            used_next = used_reg - CNT_W'(1);
        end
        res.in_use = fbpa_pkg::INUSE_W'(used_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= '0;
            stride_reg    <= fbpa_pkg::STRIDE_RESET;
            count_reg     <= '0;
            top_reg       <= EMPTY;
            used_reg      <= '0;
            clr_ctr_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_index)
                    fbpa_pkg::REG_POOL_START:   start_reg  <= cfg_data;
                    fbpa_pkg::REG_BLOCK_STRIDE: stride_reg <= cfg_data[SW-1:0];
                    fbpa_pkg::REG_BLOCK_COUNT:  count_reg  <= cfg_data[fbpa_pkg::COUNT_W-1:0];
                    default:                    count_reg  <= count_reg;
                endcase
            end
            if (cmd.clr_init)
            begin
                top_reg     <= (live != '0) ? '0 : EMPTY;
                used_reg    <= '0;
                clr_ctr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_ctr_reg <= clr_ctr_reg + IDX_W'(1);
            end
            else if (cmd.commit)
            begin
                top_reg  <= top_next;
                used_reg <= used_next;
            end
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= in_data.op;
            addr_reg <= in_data.free_address;
        end
        if (cmd.calc)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(stride_reg);
            rd_reg   <= link_mem[top_reg[IDX_W-1:0]];
        end
        if (cmd.commit)
        begin
            out_data_reg <= res;
        end
    end

    // single write port: clearing sweep or a push
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            link_mem[clr_ctr_reg] <= '0;
        end
        else if (cmd.commit && push)
        begin
            link_mem[div_quot[IDX_W-1:0]] <= {1'b1, top_reg};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.op_free   = (op_reg == fbpa_pkg::OP_FREE);
    assign status.addr_null = (addr_reg == '0);
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.clr_last  = (clr_ctr_reg == IDX_W'(MAX_BLOCKS - 1));

    `FBPA_ASSERT_IMPLY(a_top_in_range, clk, rst_n, 1'b1, top_reg <= EMPTY)
    `FBPA_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid_reg)
    `FBPA_ASSERT_IMPLY(a_push_needs_use, clk, rst_n, cmd.commit && push, used_reg != '0)

endmodule

// ----- rtl/fixed_block_pool_allocator_unit.sv -----
// Fixed-size block pool allocator.
// Requests enter on in_valid/in_ready with in_data (op, free_address); each
// request gives exactly one result on out_valid/out_ready with out_data
// (block_address, status, in_use), unless a rebuilding write drops it first.
// Pool geometry is written on the cfg port (index 0 pool_start, 1 block_stride,
// 2 block_count); cfg_ready is always high, a write to one of these rebuilds
// the pool with all blocks free, and a write to any other index is ignored.
// One request is processed at a time. An allocate or a null free (address
// zero) passes through the calc and commit states; any other free also waits
// in the divide state for the bit-serial 32-step remainder unit that checks
// stride alignment and finds the block index.
// After reset and after every rebuilding write, a clearing pass marks all
// link entries unwritten; in_ready stays low during that pass.
// Results sit in an output register: a new request is accepted while an
// earlier result waits, but its result is held back until out_ready takes the
// pending one, so a stalled receiver stops the block without loss.
module fixed_block_pool_allocator_unit #(
    parameter int MAX_BLOCKS = 1024,
    parameter int ADDR_BITS  = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  fbpa_pkg::fbpa_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output fbpa_pkg::fbpa_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data
);

    fbpa_pkg::fbpa_cmd_t    cmd;
    fbpa_pkg::fbpa_status_t status;
    logic                   cfg_fire;
    logic                   cfg_restart;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // only writes to a real register restart the pool
    assign cfg_restart = cfg_fire &&
                         ((cfg_index == fbpa_pkg::REG_POOL_START) ||
                          (cfg_index == fbpa_pkg::REG_BLOCK_STRIDE) ||
                          (cfg_index == fbpa_pkg::REG_BLOCK_COUNT));

    fbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cfg_fire (cfg_restart),
        .status   (status),
        .cmd      (cmd)
    );

    fbpa_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_fire),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
